[hdl/pls_pkg.sv]
`default_nettype none
package pls_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int VALUE_W      = 32;
   localparam int POS_W        = 6;
   localparam int INDEX_W      = 5;
   localparam int ACTION_W     = 3;
   localparam int STATUS_W     = 3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INS_HEAD = 3'd0,
      ACT_INS_END  = 3'd1,
      ACT_INS_POS  = 3'd2,
      ACT_DEL_HEAD = 3'd3,
      ACT_DEL_END  = 3'd4,
      ACT_DEL_POS  = 3'd5,
      ACT_DISPLAY  = 3'd6
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 3'd0,
      ST_ENTRY = 3'd1,
      ST_EMPTY = 3'd2,
      ST_RANGE = 3'd3,
      ST_FULL  = 3'd4
   } status_type;

endpackage
`default_nettype wire

[hdl/positional_list_store_top.sv]
`default_nettype none
// Bounded ordered list of signed 32-bit values held in a single-port-write RAM with a
// registered read. Each transaction is one edit (insert or delete at head, end or a
// position) answered by one status, or a display answered by one entry per stored value
// in order, the final one flagged by rsp_last (an empty list answers once with status
// empty). Edits are done by a sequencer that moves entries one at a time through the
// RAM, sharing one index increment/decrement and compare step: each moved entry is
// read from the RAM and then written back one place along; a display reads each entry
// and then presents it. req_stall is high while a transaction is in progress; a new
// one may be taken while the last result still waits in the output register.
module positional_list_store_top #(
   parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [pls_pkg::ACTION_W-1:0]        req_action,
   input  wire  signed [pls_pkg::VALUE_W-1:0]  req_value,
   input  wire  [pls_pkg::POS_W-1:0]           req_position,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output pls_pkg::status_type                 rsp_status,
   output logic signed [pls_pkg::VALUE_W-1:0]  rsp_entry_value,
   output logic [pls_pkg::INDEX_W-1:0]         rsp_entry_index,
   output logic                                rsp_last
);
   import pls_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SHIFT_RD = 7'b0000010,
      S_SHIFT_WR = 7'b0000100,
      S_PLACE    = 7'b0001000,
      S_RESP     = 7'b0010000,
      S_DISP_RD  = 7'b0100000,
      S_DISP_OUT = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic                ins_ff, ins_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   status_type          status_ff, status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [VALUE_W-1:0]  mem [CAPACITY];
   logic [VALUE_W-1:0]  rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [VALUE_W-1:0]  wr_data;

   logic [CW-1:0]       step;
   logic                accept;
   logic                out_free;
   logic [XW-1:0]       cnt_x;
   logic [XW-1:0]       pos_x;
   logic [XW-1:0]       op_pos;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_x     = XW'(count_ff);
   assign pos_x     = XW'(req_position);

   // shared index step: down for insert shifting, up for delete shifting and display
   assign step = ins_ff ? (idx_ff - CW'(1)) : (idx_ff + CW'(1));

   always_comb begin
      // display holds the read address so a stalled entry keeps its value
      rd_addr = (state_ff == S_DISP_RD || state_ff == S_DISP_OUT) ? idx_ff[AW-1:0]
                                                                  : step[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_data_ff;
      if (state_ff == S_SHIFT_WR) begin
         wr_en = 1'b1;
      end else if (state_ff == S_PLACE) begin
         wr_en   = 1'b1;
         wr_addr = pos_ff[AW-1:0];
         wr_data = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      ins_in        = ins_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      op_pos        = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in = req_value;
               case (req_action)
                  ACT_INS_HEAD, ACT_INS_END, ACT_INS_POS: begin
                     case (req_action)
                        ACT_INS_HEAD: op_pos = '0;
                        ACT_INS_END:  op_pos = cnt_x;
                        default:      op_pos = pos_x;
                     endcase
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = ST_FULL;
                        state_in  = S_RESP;
                     end else if (op_pos > cnt_x) begin
                        status_in = ST_RANGE;
                        state_in  = S_RESP;
                     end else begin
                        pos_in   = CW'(op_pos);
                        idx_in   = count_ff;
                        ins_in   = 1'b1;
                        state_in = (cnt_x > op_pos) ? S_SHIFT_RD : S_PLACE;
                     end
                  end
                  ACT_DEL_HEAD, ACT_DEL_END, ACT_DEL_POS: begin
                     case (req_action)
                        ACT_DEL_HEAD: op_pos = '0;
                        ACT_DEL_END:  op_pos = cnt_x - XW'(1);
                        default:      op_pos = pos_x;
                     endcase
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_RESP;
                     end else if (op_pos >= cnt_x) begin
                        status_in = ST_RANGE;
                        state_in  = S_RESP;
                     end else begin
                        idx_in = CW'(op_pos);
                        ins_in = 1'b0;
                        if ((op_pos + XW'(1)) < cnt_x) begin
                           state_in = S_SHIFT_RD;
                        end else begin
                           count_in  = count_ff - CW'(1);
                           status_in = ST_DONE;
                           state_in  = S_RESP;
                        end
                     end
                  end
                  ACT_DISPLAY: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        idx_in   = '0;
                        ins_in   = 1'b0;
                        state_in = S_DISP_RD;
                     end
                  end
                  default: begin
                     status_in = ST_DONE;
                     state_in  = S_RESP;
                  end
               endcase
            end
         end
         S_SHIFT_RD: begin
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            idx_in = step;
            if (ins_ff) begin
               state_in = (step > pos_ff) ? S_SHIFT_RD : S_PLACE;
            end else if ((step + CW'(1)) < count_ff) begin
               state_in = S_SHIFT_RD;
            end else begin
               count_in  = count_ff - CW'(1);
               status_in = ST_DONE;
               state_in  = S_RESP;
            end
         end
         S_PLACE: begin
            count_in  = count_ff + CW'(1);
            status_in = ST_DONE;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = '0;
               rsp_index_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DISP_RD: begin
            state_in = S_DISP_OUT;
         end
         S_DISP_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_ENTRY;
               rsp_value_in  = rd_data_ff;
               rsp_index_in  = INDEX_W'(idx_ff);
               rsp_last_in   = (step == count_ff);
               if (step == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = step;
                  state_in = S_DISP_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      ins_ff        <= ins_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_last        = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> (count_ff == $past(count_ff) + CW'(1)) ||
                             (count_ff == $past(count_ff) - CW'(1)))
      else $error("entry count moved by more than one");

   a_disp_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DISP_RD || state_ff == S_DISP_OUT) |=> $stable(count_ff))
      else $error("entry count changed during display");

   a_not_last_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_status == ST_ENTRY))
      else $error("non-final result that is not a display entry");

endmodule
`default_nettype wire
